### hdl/bvx_pkg.sv
// Shared constants, action codes and controller/datapath interface structs
// for the box voxelizer. No dependencies.
`timescale 1ns / 1ps

package bvx_pkg;

  // edge coordinate format
  localparam int EDGE_W             = 14;
  localparam int EDGE_FRACTION_BITS = 12;
  localparam int SCALE_SHIFT        = EDGE_FRACTION_BITS - 4;
  localparam int CENTRE_OFFSET      = 15 * (2 ** (SCALE_SHIFT - 1));

  // width of the biased edge sums, wide enough for any edge plus offset
  localparam int SUM_W = ((EDGE_W > SCALE_SHIFT + 4) ? EDGE_W : SCALE_SHIFT + 4) + 2;

  // bitmap geometry
  localparam int CELLS      = 16;
  localparam int CELL_IDX_W = 4;
  localparam int ROWS       = CELLS * CELLS;
  localparam int ROW_IDX_W  = 2 * CELL_IDX_W;

  // cell counters
  localparam int CNT_W = 13;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_ADD     = 2'd1,
    ACT_READ    = 2'd2,
    ACT_CNT_RST = 2'd3
  } action_e;

  // controller to datapath
  typedef struct packed {
    logic capture;     // latch the accepted item
    logic span_latch;  // latch cell ranges, start row walk
    logic issue;       // read the current box row and advance
    logic issue_cell;  // read the row of the addressed cell
    logic finish;      // update total and load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    action_e act;
    logic    empty;     // box covers no cell centre
    logic    last_row;  // current row is the final row of the box
    logic    out_free;  // result register can take a new result
  } sts_t;

endpackage

### hdl/box_voxelizer_16cube.sv
// Add box: capture, range latch, sweep of the covered y*z rows (up to 256),
// one row read-modify-write per cycle through the bitmap memory port, drain
// and finish; a box missing every centre, clear and count reset skip the sweep,
// read fetches one row. A new item waits until the result is registered.
// Reset (async, active low) clears the per-row valid bits, so the whole
// bitmap reads empty at once, and zeroes the running total.
`timescale 1ns / 1ps

module box_voxelizer_16cube import bvx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               action_i,
  input  logic signed [EDGE_W-1:0] x_end_a_i,
  input  logic signed [EDGE_W-1:0] x_end_b_i,
  input  logic signed [EDGE_W-1:0] y_end_a_i,
  input  logic signed [EDGE_W-1:0] y_end_b_i,
  input  logic signed [EDGE_W-1:0] z_end_a_i,
  input  logic signed [EDGE_W-1:0] z_end_b_i,
  input  logic [CELL_IDX_W-1:0]    cell_x_i,
  input  logic [CELL_IDX_W-1:0]    cell_y_i,
  input  logic [CELL_IDX_W-1:0]    cell_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CNT_W-1:0]         added_cells_o,
  output logic [CNT_W-1:0]         running_added_o,
  output logic                     cell_value_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  bvx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // bitmap, ranges and counters
  bvx_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .x_end_a_i       (x_end_a_i),
    .x_end_b_i       (x_end_b_i),
    .y_end_a_i       (y_end_a_i),
    .y_end_b_i       (y_end_b_i),
    .z_end_a_i       (z_end_a_i),
    .z_end_b_i       (z_end_b_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_z_i        (cell_z_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .added_cells_o   (added_cells_o),
    .running_added_o (running_added_o),
    .cell_value_o    (cell_value_o)
  );

endmodule

### hdl/bvx_ctrl.sv
// Sequencing state machine of the box voxelizer.
// Depends on bvx_pkg for the command and status structs.
`timescale 1ns / 1ps

module bvx_ctrl import bvx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAN,
    S_SWEEP,
    S_DRAIN,
    S_READ,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SPAN;
      end
      S_SPAN: begin
        if (sts_i.act == ACT_ADD && !sts_i.empty) begin
          state_d = S_SWEEP;
        end else if (sts_i.act == ACT_READ) begin
          state_d = S_READ;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_SWEEP: begin
        if (sts_i.last_row) state_d = S_DRAIN;
      end
      S_DRAIN:  state_d = S_FINISH;
      S_READ:   state_d = S_FINISH;
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // commands decoded from state
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o            = '0;
    cmd_o.capture    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.span_latch = (state_q == S_SPAN);
    cmd_o.issue      = (state_q == S_SWEEP);
    cmd_o.issue_cell = (state_q == S_READ);
    cmd_o.finish     = (state_q == S_FINISH) && sts_i.out_free;
  end

endmodule

### hdl/bvx_datapath.sv
// Datapath of the box voxelizer: item registers, cell range math, row
// bitmap memory with per-row valid bits, counters and the result register.
// Depends on bvx_pkg.
`timescale 1ns / 1ps

module bvx_datapath import bvx_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  input  logic [1:0]               action_i,
  input  logic signed [EDGE_W-1:0] x_end_a_i,
  input  logic signed [EDGE_W-1:0] x_end_b_i,
  input  logic signed [EDGE_W-1:0] y_end_a_i,
  input  logic signed [EDGE_W-1:0] y_end_b_i,
  input  logic signed [EDGE_W-1:0] z_end_a_i,
  input  logic signed [EDGE_W-1:0] z_end_b_i,
  input  logic [CELL_IDX_W-1:0]    cell_x_i,
  input  logic [CELL_IDX_W-1:0]    cell_y_i,
  input  logic [CELL_IDX_W-1:0]    cell_z_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [CNT_W-1:0]         added_cells_o,
  output logic [CNT_W-1:0]         running_added_o,
  output logic                     cell_value_o
);

  typedef struct packed {
    logic                  ok;
    logic [CELL_IDX_W-1:0] lo;
    logic [CELL_IDX_W-1:0] hi;
  } span_t;

  localparam logic signed [SUM_W-1:0] LoBias  = SUM_W'(CENTRE_OFFSET + 2 ** SCALE_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] HiBias  = SUM_W'(CENTRE_OFFSET);
  localparam logic signed [SUM_W-1:0] CellMax = SUM_W'(CELLS - 1);

  // covered cell range on one axis, ends in either order
  function automatic span_t axis_span(input logic signed [EDGE_W-1:0] a,
                                      input logic signed [EDGE_W-1:0] b);
    logic signed [EDGE_W-1:0] lo;
    logic signed [EDGE_W-1:0] hi;
    logic signed [SUM_W-1:0]  c0;
    logic signed [SUM_W-1:0]  c1;
    span_t                    s;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    c0 = (SUM_W'(lo) + LoBias) >>> SCALE_SHIFT;
    c1 = (SUM_W'(hi) + HiBias) >>> SCALE_SHIFT;
    if (c0[SUM_W-1]) c0 = '0;
    if (c1 > CellMax) c1 = CellMax;
    s.ok = (c0 <= c1);
    s.lo = c0[CELL_IDX_W-1:0];
    s.hi = c1[CELL_IDX_W-1:0];
    return s;
  endfunction

  // captured item
  action_e                  act_q;
  logic signed [EDGE_W-1:0] xa_q, xb_q, ya_q, yb_q, za_q, zb_q;
  logic [CELL_IDX_W-1:0]    cx_q, cy_q, cz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACT_READ;
    end else if (cmd_i.capture) begin
      act_q <= action_e'(action_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      xa_q <= x_end_a_i;
      xb_q <= x_end_b_i;
      ya_q <= y_end_a_i;
      yb_q <= y_end_b_i;
      za_q <= z_end_a_i;
      zb_q <= z_end_b_i;
      cx_q <= cell_x_i;
      cy_q <= cell_y_i;
      cz_q <= cell_z_i;
    end
  end

  // cell ranges from the captured edges
  span_t            sx, sy, sz;
  logic [CELLS-1:0] span_bits;

  always_comb begin
    sx = axis_span(xa_q, xb_q);
    sy = axis_span(ya_q, yb_q);
    sz = axis_span(za_q, zb_q);
    for (int i = 0; i < CELLS; i++) begin
      span_bits[i] = (CELL_IDX_W'(i) >= sx.lo) && (CELL_IDX_W'(i) <= sx.hi);
    end
  end

  // row walk over the box, y inner and z outer
  logic [CELLS-1:0]      span_bits_q;
  logic [CELL_IDX_W-1:0] y0_q, y1_q, z1_q, y_q, z_q;
  logic                  last_row;

  assign last_row = (y_q == y1_q) && (z_q == z1_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.span_latch) begin
      span_bits_q <= span_bits;
      y0_q        <= sy.lo;
      y1_q        <= sy.hi;
      z1_q        <= sz.hi;
      y_q         <= sy.lo;
      z_q         <= sz.lo;
    end else if (cmd_i.issue) begin
      if (y_q == y1_q) begin
        y_q <= y0_q;
        z_q <= z_q + 1'b1;
      end else begin
        y_q <= y_q + 1'b1;
      end
    end
  end

  // row memory, read registered, written back in the cycle after the read
  logic [CELLS-1:0]     mem_q [ROWS];
  logic [CELLS-1:0]     rdata_q;
  logic                 rvalid_q;
  logic [ROWS-1:0]      row_valid_q;
  logic [ROW_IDX_W-1:0] raddr, wb_addr_q;
  logic                 rd_en, pending_q;
  logic [CELLS-1:0]     row_old, new_bits;

  assign rd_en    = cmd_i.issue || cmd_i.issue_cell;
  assign raddr    = cmd_i.issue_cell ? {cz_q, cy_q} : {z_q, y_q};
  assign row_old  = rvalid_q ? rdata_q : '0;
  assign new_bits = span_bits_q & ~row_old;

  always_ff @(posedge clk_i) begin
    if (pending_q) mem_q[wb_addr_q] <= row_old | new_bits;
    if (rd_en) rdata_q <= mem_q[raddr];
    if (cmd_i.issue) wb_addr_q <= raddr;
  end

  // per-row valid bits; a row never written reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rvalid_q    <= 1'b0;
      pending_q   <= 1'b0;
    end else begin
      pending_q <= cmd_i.issue;
      if (rd_en) rvalid_q <= row_valid_q[raddr];
      if (cmd_i.finish && act_q == ACT_CLEAR) begin
        row_valid_q <= '0;
      end else if (pending_q) begin
        row_valid_q[wb_addr_q] <= 1'b1;
      end
    end
  end

  // count of cells newly set by the current box
  logic [CNT_W-1:0] added_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.span_latch) begin
      added_q <= '0;
    end else if (pending_q) begin
      added_q <= added_q + CNT_W'($countones(new_bits));
    end
  end

  // running total
  logic [CNT_W-1:0] total_q, total_d;

  always_comb begin
    unique case (act_q)
      ACT_CLEAR:   total_d = '0;
      ACT_ADD:     total_d = total_q + added_q;
      ACT_READ:    total_d = total_q;
      ACT_CNT_RST: total_d = '0;
      default:     total_d = total_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cmd_i.finish) begin
      total_q <= total_d;
    end
  end

  // result register
  logic             out_valid_q;
  logic [CNT_W-1:0] res_added_q, res_running_q;
  logic             res_cell_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_added_q   <= (act_q == ACT_ADD) ? added_q : '0;
      res_running_q <= total_d;
      res_cell_q    <= (act_q == ACT_READ) && rvalid_q && rdata_q[cx_q];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign added_cells_o   = res_added_q;
  assign running_added_o = res_running_q;
  assign cell_value_o    = res_cell_q;

  // status to the controller
  always_comb begin
    sts_o          = '0;
    sts_o.act      = act_q;
    sts_o.empty    = !(sx.ok && sy.ok && sz.ok);
    sts_o.last_row = last_row;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

endmodule
